// File: src/ftpc_pkg.sv
// ----------------------------------------------------------------------------
// ftpc_pkg: shared types and constants of the flow table packet counter
// Packet header, classified item and result layouts, class/status codes.
// ----------------------------------------------------------------------------
package ftpc_pkg;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_TCP   = 2'd1,
    CLS_UDP   = 2'd2,
    CLS_SKIP  = 2'd3
  } pkt_class_t;

  typedef enum logic [1:0] {
    FS_NONE = 2'd0,
    FS_HIT  = 2'd1,
    FS_NEW  = 2'd2,
    FS_FULL = 2'd3
  } flow_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE
  } back_state_t;

  // one parsed packet header
  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] cap_len;
  } in_item_t;

  // one result
  typedef struct packed {
    pkt_class_t   pkt_class;
    flow_status_t flow_status;
    logic [31:0]  flows_total;
    logic [31:0]  flows_tcp;
    logic [31:0]  flows_udp;
    logic [31:0]  packets_total;
    logic [31:0]  packets_tcp;
    logic [31:0]  packets_udp;
    logic [31:0]  bytes_tcp;
    logic [31:0]  bytes_udp;
  } out_item_t;

  // five-tuple as stored in the flow table
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
  } flow_key_t;

  // packet and byte counters owned by the front end
  typedef struct packed {
    logic [31:0] packets_total;
    logic [31:0] packets_tcp;
    logic [31:0] packets_udp;
    logic [31:0] bytes_tcp;
    logic [31:0] bytes_udp;
  } pkt_cnt_t;

  // classified item passed from front to back
  typedef struct packed {
    pkt_class_t cls;
    flow_key_t  key;
    pkt_cnt_t   cnts;
  } cls_item_t;

endpackage

// File: src/ftpc_fifo.sv
// ----------------------------------------------------------------------------
// ftpc_fifo: small register queue
// Flop-based FIFO with full/empty flags, used between pipeline parts.
// ----------------------------------------------------------------------------
module ftpc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  data_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = data_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/ftpc_front.sv
// ----------------------------------------------------------------------------
// ftpc_front: header intake and classification
// Classifies each header, keeps packet and byte counters, forms the key.
// ----------------------------------------------------------------------------
module ftpc_front
  import ftpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      q_push,
  input  logic      q_full,
  output cls_item_t q_item
);

  pkt_cnt_t   cnt_r, cnt_nxt;
  logic       accept;
  logic       is_tcp, is_udp, is_ip;
  pkt_class_t cls;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;

  // classification
  always_comb begin
    is_tcp = (in_item.ip_protocol == PROTO_TCP);
    is_udp = (in_item.ip_protocol == PROTO_UDP);
    is_ip  = (in_item.eth_type == ETH_IPV4) || (in_item.eth_type == ETH_IPV6);
    if (!is_tcp && !is_udp) begin
      cls = CLS_OTHER;
    end else if (!is_ip) begin
      cls = CLS_SKIP;
    end else if (is_tcp) begin
      cls = CLS_TCP;
    end else begin
      cls = CLS_UDP;
    end
  end

  // counter update, all wrap at 32 bits
  always_comb begin
    cnt_nxt               = cnt_r;
    cnt_nxt.packets_total = cnt_r.packets_total + 32'd1;
    if (is_tcp) begin
      cnt_nxt.packets_tcp = cnt_r.packets_tcp + 32'd1;
    end
    if (is_udp) begin
      cnt_nxt.packets_udp = cnt_r.packets_udp + 32'd1;
    end
    if (cls == CLS_TCP) begin
      cnt_nxt.bytes_tcp = cnt_r.bytes_tcp + {16'd0, in_item.cap_len};
    end
    if (cls == CLS_UDP) begin
      cnt_nxt.bytes_udp = cnt_r.bytes_udp + {16'd0, in_item.cap_len};
    end
  end

  // classified transaction toward the back end
  always_comb begin
    q_item.cls       = cls;
    q_item.key.src   = in_item.src_addr;
    q_item.key.dst   = in_item.dst_addr;
    q_item.key.ports = {in_item.src_port, in_item.dst_port};
    q_item.key.proto = in_item.ip_protocol;
    q_item.cnts      = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/ftpc_back.sv
// ----------------------------------------------------------------------------
// ftpc_back: flow table lookup and insert
// Walks the filled part of the table one entry a cycle, then inserts or
// reports, updates the flow counters and emits the result.
// ----------------------------------------------------------------------------
module ftpc_back
  import ftpc_pkg::*;
#(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  output logic      q_pop,
  input  cls_item_t q_item,
  input  logic      o_full,
  output logic      o_push,
  output out_item_t o_item
);

  localparam int CW = $clog2(FLOW_ENTRIES + 1);
  localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  back_state_t state_r, state_nxt;
  cls_item_t   cur_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          chk_r, chk_nxt;
  logic          hit_r, hit_nxt;
  logic [31:0]   flows_r, flows_nxt;
  logic [31:0]   ftcp_r, ftcp_nxt;
  logic [31:0]   fudp_r, fudp_nxt;

  flow_key_t tbl_mem [FLOW_ENTRIES];
  flow_key_t rd_key_r;
  logic      rd_en, wr_en;
  logic      match, lookup, scan_done;
  flow_status_t status;

  // valid entries are exactly those below the fill count
  assign match     = chk_r && (rd_key_r == cur_r.key);
  assign lookup    = (cur_r.cls == CLS_TCP) || (cur_r.cls == CLS_UDP);
  assign scan_done = match || (idx_r == fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if ((q_item.cls == CLS_TCP) || (q_item.cls == CLS_UDP)) begin
            state_nxt = B_SCAN;
          end else begin
            state_nxt = B_WRITE;
          end
        end
      end
      B_SCAN: begin
        if (scan_done) begin
          state_nxt = B_WRITE;
        end
      end
      B_WRITE: begin
        if (!o_full) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    o_push    = 1'b0;
    status    = FS_NONE;
    idx_nxt   = idx_r;
    chk_nxt   = 1'b0;
    hit_nxt   = hit_r;
    fill_nxt  = fill_r;
    flows_nxt = flows_r;
    ftcp_nxt  = ftcp_r;
    fudp_nxt  = fudp_r;
    unique case (state_r)
      B_IDLE: begin
        q_pop   = !q_empty;
        idx_nxt = '0;
        hit_nxt = 1'b0;
      end
      B_SCAN: begin
        if (match) begin
          hit_nxt = 1'b1;
        end else if (idx_r < fill_r) begin
          rd_en   = 1'b1;
          chk_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      B_WRITE: begin
        if (!lookup) begin
          status = FS_NONE;
        end else if (hit_r) begin
          status = FS_HIT;
        end else if (fill_r == CW'(FLOW_ENTRIES)) begin
          status = FS_FULL;
        end else begin
          status = FS_NEW;
        end
        if (!o_full) begin
          o_push = 1'b1;
          if (status == FS_NEW) begin
            wr_en     = 1'b1;
            fill_nxt  = fill_r + 1'b1;
            flows_nxt = flows_r + 32'd1;
            if (cur_r.key.proto == PROTO_TCP) begin
              ftcp_nxt = ftcp_r + 32'd1;
            end else if (cur_r.key.proto == PROTO_UDP) begin
              fudp_nxt = fudp_r + 32'd1;
            end
          end
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // result transaction
  always_comb begin
    o_item.pkt_class     = cur_r.cls;
    o_item.flow_status   = status;
    o_item.flows_total   = flows_nxt;
    o_item.flows_tcp     = ftcp_nxt;
    o_item.flows_udp     = fudp_nxt;
    o_item.packets_total = cur_r.cnts.packets_total;
    o_item.packets_tcp   = cur_r.cnts.packets_tcp;
    o_item.packets_udp   = cur_r.cnts.packets_udp;
    o_item.bytes_tcp     = cur_r.cnts.bytes_tcp;
    o_item.bytes_udp     = cur_r.cnts.bytes_udp;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      fill_r  <= '0;
      chk_r   <= 1'b0;
      hit_r   <= 1'b0;
      flows_r <= '0;
      ftcp_r  <= '0;
      fudp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      chk_r   <= chk_nxt;
      hit_r   <= hit_nxt;
      flows_r <= flows_nxt;
      ftcp_r  <= ftcp_nxt;
      fudp_r  <= fudp_nxt;
    end
  end

  // current transaction
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
  end

  // flow table: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= tbl_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[fill_r[AW-1:0]] <= cur_r.key;
    end
  end

endmodule

// File: src/flow_table_packet_counter.sv
// ----------------------------------------------------------------------------
// flow_table_packet_counter: five-tuple flow table with packet counters
// Front end classifies headers and counts packets/bytes; back end looks up
// and inserts flows. Two-entry queues separate them and buffer the results.
// ----------------------------------------------------------------------------
//  channel | ports                         | transaction when
//  --------+-------------------------------+-----------------------------
//  input   | in_push, in_full, in_item     | in_push && !in_full
//  result  | out_pop, out_empty, out_item  | out_pop && !out_empty
//
// A TCP/UDP packet with an IP ethertype walks the N flows recorded so far in
// the back end, stopping early on a match; the table walk reads one entry per
// cycle from its single read port. Other packets go from idle straight to the
// write state. Reset empties the table at once (fill count) and clears all
// counters. Either side may stall; the queues hold up to two transactions.
// ----------------------------------------------------------------------------
module flow_table_packet_counter
  import ftpc_pkg::*;
#(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  localparam int QUEUE_DEPTH = 2;

  logic      q_push, q_full, q_pop, q_empty;
  cls_item_t q_wr_item, q_rd_item;
  logic [$bits(cls_item_t)-1:0] q_rd_data;
  logic      o_push, o_full;
  out_item_t o_item;
  logic [$bits(out_item_t)-1:0] o_rd_data;

  ftpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_item  (q_wr_item)
  );

  ftpc_fifo #(
    .W     ($bits(cls_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_item),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  assign q_rd_item = cls_item_t'(q_rd_data);

  ftpc_back #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_rd_item),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  ftpc_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (o_push),
    .full    (o_full),
    .wr_data (o_item),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (o_rd_data)
  );

  assign out_item = out_item_t'(o_rd_data);

  // back end never pushes a result into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full)
    else $error("result pushed while result queue full");

  // back end only takes a transaction that is there
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("classified queue popped while empty");

  // a flow lookup is reported only for IP TCP/UDP packets
  a_status_class: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && (o_item.flow_status != FS_NONE)) |->
      ((o_item.pkt_class == CLS_TCP) || (o_item.pkt_class == CLS_UDP)))
    else $error("flow status reported for a packet without lookup");

endmodule

// File: verif/tb_flow_table_packet_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flow_table_packet_counter: self-checking testbench of the flow counter
// Drives parsed packet headers through the push/full queue interface and
// checks every popped result against a scoreboard model of the flow table
// and counters. Directed corner cases come first, then random traffic that
// fills the table, a long receiver hold-off and traffic on a full table.
// ----------------------------------------------------------------------------
module tb_flow_table_packet_counter;
  import ftpc_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_PCT    = 23;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_push  = 1'b0;
  logic      in_full;
  in_item_t  in_item  = '0;
  logic      out_pop  = 1'b0;
  logic      out_empty;
  out_item_t out_item;

  // scoreboard copy of the flow table and counters
  bit          flow_used [TABLE_DEPTH];
  flow_key_t   flow_keys [TABLE_DEPTH];
  logic [31:0] n_flows, n_flows_tcp, n_flows_udp;
  logic [31:0] n_pkts, n_pkts_tcp, n_pkts_udp;
  logic [31:0] n_bytes_tcp, n_bytes_udp;

  out_item_t   pending_results[$];
  flow_key_t   key_pool[$];
  int          status_seen[4];
  int          n_sent      = 0;
  int          n_checked   = 0;
  int          n_errors    = 0;
  int          quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          hold_off_req = 1'b0;

  flow_table_packet_counter #(.FLOW_ENTRIES(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // count cycles without any transaction on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("tb_flow_table_packet_counter: FAIL");
    $finish;
  end

  // counter update and flow lookup for one header; returns the expected result
  function automatic out_item_t count_packet(input in_item_t h);
    out_item_t r;
    flow_key_t k;
    logic      is_ip;
    logic      tcp;
    logic      hit;
    int        free_idx;
    r.pkt_class   = CLS_OTHER;
    r.flow_status = FS_NONE;
    is_ip = (h.eth_type == ETH_IPV4) || (h.eth_type == ETH_IPV6);
    n_pkts = n_pkts + 1;
    if (h.ip_protocol == PROTO_TCP || h.ip_protocol == PROTO_UDP) begin
      tcp = (h.ip_protocol == PROTO_TCP);
      if (tcp) n_pkts_tcp = n_pkts_tcp + 1;
      else     n_pkts_udp = n_pkts_udp + 1;
      if (!is_ip) begin
        r.pkt_class = CLS_SKIP;
      end else begin
        r.pkt_class = tcp ? CLS_TCP : CLS_UDP;
        if (tcp) n_bytes_tcp = n_bytes_tcp + {16'b0, h.cap_len};
        else     n_bytes_udp = n_bytes_udp + {16'b0, h.cap_len};
        k.src   = h.src_addr;
        k.dst   = h.dst_addr;
        k.ports = {h.src_port, h.dst_port};
        k.proto = h.ip_protocol;
        hit      = 1'b0;
        free_idx = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (flow_used[i]) begin
            if (flow_keys[i] == k) hit = 1'b1;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit) begin
          r.flow_status = FS_HIT;
        end else if (free_idx < 0) begin
          r.flow_status = FS_FULL;
        end else begin
          // new flow goes to the lowest free entry
          flow_used[free_idx] = 1'b1;
          flow_keys[free_idx] = k;
          n_flows = n_flows + 1;
          if (tcp) n_flows_tcp = n_flows_tcp + 1;
          else     n_flows_udp = n_flows_udp + 1;
          r.flow_status = FS_NEW;
        end
      end
    end
    status_seen[r.flow_status]++;
    r.flows_total   = n_flows;
    r.flows_tcp     = n_flows_tcp;
    r.flows_udp     = n_flows_udp;
    r.packets_total = n_pkts;
    r.packets_tcp   = n_pkts_tcp;
    r.packets_udp   = n_pkts_udp;
    r.bytes_tcp     = n_bytes_tcp;
    r.bytes_udp     = n_bytes_udp;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result transaction with nothing expected");
      n_errors++;
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      compare_field("pkt_class",     want.pkt_class,     got.pkt_class);
      compare_field("flow_status",   want.flow_status,   got.flow_status);
      compare_field("flows_total",   want.flows_total,   got.flows_total);
      compare_field("flows_tcp",     want.flows_tcp,     got.flows_tcp);
      compare_field("flows_udp",     want.flows_udp,     got.flows_udp);
      compare_field("packets_total", want.packets_total, got.packets_total);
      compare_field("packets_tcp",   want.packets_tcp,   got.packets_tcp);
      compare_field("packets_udp",   want.packets_udp,   got.packets_udp);
      compare_field("bytes_tcp",     want.bytes_tcp,     got.bytes_tcp);
      compare_field("bytes_udp",     want.bytes_udp,     got.bytes_udp);
    end
  endtask

  // result side: pop at random, honor hold-off requests
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) check_result(out_item);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  // offer one header and wait for its transaction
  task automatic push_header(input in_item_t h);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= h;
    do @(posedge clk); while (in_full);
    pending_results.push_back(count_packet(h));
    n_sent++;
  endtask

  function automatic in_item_t hdr(input logic [15:0] et, input logic [7:0] proto,
                                   input logic [31:0] s, input logic [31:0] d,
                                   input logic [15:0] sp, input logic [15:0] dp,
                                   input logic [15:0] len);
    in_item_t h;
    h.eth_type    = et;
    h.ip_protocol = proto;
    h.src_addr    = s;
    h.dst_addr    = d;
    h.src_port    = sp;
    h.dst_port    = dp;
    h.cap_len     = len;
    return h;
  endfunction

  function automatic flow_key_t fresh_key();
    flow_key_t k;
    k.src   = $urandom;
    k.dst   = $urandom;
    k.ports = $urandom;
    k.proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    key_pool.push_back(k);
    return k;
  endfunction

  // random header: mostly known flows, some new ones, near misses and noise
  function automatic in_item_t make_header(input int reuse_pct);
    in_item_t    h;
    flow_key_t   k;
    int unsigned r;
    if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
      // near miss: one bit of address or ports differs
      if ($urandom_range(9) == 0) k[103:8] = k[103:8] ^ (96'b1 << $urandom_range(95));
    end else begin
      k = fresh_key();
    end
    h.src_addr    = k.src;
    h.dst_addr    = k.dst;
    h.src_port    = k.ports[31:16];
    h.dst_port    = k.ports[15:0];
    h.ip_protocol = k.proto;
    h.cap_len     = 16'($urandom);
    r = $urandom_range(19);
    if (r < 2) begin
      h.eth_type = 16'($urandom);
    end else if (r < 3) begin
      h.eth_type    = ETH_IPV4;
      h.ip_protocol = 8'($urandom);
    end else if (r < 12) begin
      h.eth_type = ETH_IPV4;
    end else begin
      h.eth_type = ETH_IPV6;
    end
    return h;
  endfunction

  // corner cases: classes, skipped ethertypes, extremes, tuple field order
  task automatic test_directed();
    push_header(hdr(ETH_IPV4, 8'h00, '0, '0, '0, '0, '0));
    push_header(hdr(16'hFFFF, 8'hFF, '1, '1, '1, '1, '1));
    push_header(hdr(16'h0000, PROTO_TCP, '1, '0, '1, '0, 16'hFFFF));
    push_header(hdr(16'hFFFF, PROTO_UDP, '0, '1, '0, '1, 16'hFFFF));
    push_header(hdr(16'h0801, PROTO_TCP, 32'h1, 32'h2, 16'd3, 16'd4, 16'd60));
    push_header(hdr(16'h86DC, PROTO_UDP, 32'h1, 32'h2, 16'd3, 16'd4, 16'd60));
    push_header(hdr(ETH_IPV4, 8'd5, 32'h1, 32'h2, 16'd3, 16'd4, 16'd60));
    push_header(hdr(ETH_IPV6, 8'd18, 32'h1, 32'h2, 16'd3, 16'd4, 16'd60));
    // all-zero and all-one tuples
    push_header(hdr(ETH_IPV4, PROTO_TCP, '0, '0, '0, '0, 16'h0000));
    push_header(hdr(ETH_IPV4, PROTO_TCP, '1, '1, '1, '1, 16'hFFFF));
    // same tuple under the other IP ethertype is the same flow
    push_header(hdr(ETH_IPV6, PROTO_TCP, '1, '1, '1, '1, 16'hFFFF));
    push_header(hdr(ETH_IPV4, PROTO_UDP, '1, '1, '1, '1, 16'hFFFF));
    push_header(hdr(ETH_IPV6, PROTO_UDP, '0, '0, '0, '0, 16'h0000));
    // swapped ports and swapped addresses are distinct flows
    push_header(hdr(ETH_IPV4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 16'd64));
    push_header(hdr(ETH_IPV4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd80, 16'd1234, 16'd64));
    push_header(hdr(ETH_IPV4, PROTO_TCP, 32'h0A000002, 32'h0A000001, 16'd1234, 16'd80, 16'd64));
    push_header(hdr(ETH_IPV4, PROTO_UDP, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 16'd64));
    push_header(hdr(ETH_IPV4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 16'd1500));
    push_header(hdr(ETH_IPV6, PROTO_UDP, 32'hC0A80001, 32'hE0000001, 16'd53, 16'd53, 16'd512));
    push_header(hdr(ETH_IPV6, PROTO_UDP, 32'hC0A80001, 32'hE0000001, 16'd53, 16'd53, 16'd1));
  endtask

  task automatic run_random_traffic(input int n, input int reuse_pct);
    for (int i = 0; i < n; i++) push_header(make_header(reuse_pct));
  endtask

  // random mix while the table fills up
  task automatic test_random_traffic();
    run_random_traffic(520, 85);
  endtask

  // receiver holds off while headers keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    run_random_traffic(30, 80);
  endtask

  // fill any free entries, then hits and drops on a full table
  task automatic test_table_full();
    flow_key_t k;
    while (n_flows < TABLE_DEPTH) begin
      k = fresh_key();
      push_header(hdr($urandom_range(1) ? ETH_IPV4 : ETH_IPV6, k.proto, k.src, k.dst,
                      k.ports[31:16], k.ports[15:0], 16'($urandom)));
    end
    idle_on = 1'b0;
    run_random_traffic(200, 70);
    idle_on = 1'b1;
    run_random_traffic(300, 70);
  endtask

  // main sequence
  initial begin
    foreach (flow_used[i]) flow_used[i] = 1'b0;
    n_flows     = '0;
    n_flows_tcp = '0;
    n_flows_udp = '0;
    n_pkts      = '0;
    n_pkts_tcp  = '0;
    n_pkts_udp  = '0;
    n_bytes_tcp = '0;
    n_bytes_udp = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_table_full();
    in_push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
    end

    $display("tb_flow_table_packet_counter: %0d headers sent, %0d results checked",
             n_sent, n_checked);
    $display("flow lookups: none %0d, hit %0d, new %0d, table full %0d",
             status_seen[FS_NONE], status_seen[FS_HIT], status_seen[FS_NEW],
             status_seen[FS_FULL]);
    if (n_errors == 0) begin
      $display("tb_flow_table_packet_counter: PASS");
    end else begin
      $display("tb_flow_table_packet_counter: FAIL");
    end
    $finish;
  end

endmodule

// File: flow_table_packet_counter.f
src/ftpc_pkg.sv
src/ftpc_fifo.sv
src/ftpc_front.sv
src/ftpc_back.sv
src/flow_table_packet_counter.sv
verif/tb_flow_table_packet_counter.sv
